FILE: rtl/mcss_pkg.sv
// ----------------------------------------------------------------------------
// mcss_pkg
// Shared types and constants for the multi-channel servo slewer: transaction
// payloads, request kinds and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package mcss_pkg;

   localparam int CHANNELS   = 16;
   localparam int CHAN_W     = 4;
   localparam int ANGLE_W    = 8;
   localparam int SPEED_W    = 6;
   localparam int STEP_W     = 7;
   localparam int MASK_W     = 16;
   localparam int KIND_W     = 2;

   localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(180);
   localparam logic [STEP_W-1:0]  STEP_BASE = STEP_W'(65);
   localparam logic [CHAN_W-1:0]  LAST_CHAN = CHAN_W'(CHANNELS - 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_SET  = 2'd0,
      KIND_READ = 2'd1,
      KIND_TICK = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHAN_W-1:0]  channel;
      logic [ANGLE_W-1:0] angle;
      logic [SPEED_W-1:0] speed;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  read_channel;
      logic [ANGLE_W-1:0] position;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              set_target;
      logic              capture;
      logic              use_held;
      logic              load_rsp;
      logic              advance;
      logic [CHAN_W-1:0] tick_index;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_free;
   } status_type;

endpackage

FILE: rtl/mcss_datapath.sv
// ----------------------------------------------------------------------------
// mcss_datapath
// Channel state (current, target, speed), the present mask, the slew step
// unit and the response register.
// ----------------------------------------------------------------------------
module mcss_datapath
   import mcss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  req_type             req_data,
   input  logic                csr_valid,
   input  logic [MASK_W-1:0]   csr_data,
   input  cmd_type             cmd,
   output status_type          status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data
);

   logic [ANGLE_W-1:0] current_ff [CHANNELS];
   logic [ANGLE_W-1:0] target_ff  [CHANNELS];
   logic [SPEED_W-1:0] speed_ff   [CHANNELS];
   logic [MASK_W-1:0]  mask_ff;
   logic [CHAN_W-1:0]  held_ch_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;

   logic [CHAN_W-1:0]  addr;
   logic [ANGLE_W-1:0] cur;
   logic [ANGLE_W-1:0] tgt;
   logic [STEP_W-1:0]  step;
   logic [ANGLE_W-1:0] diff_up;
   logic [ANGLE_W-1:0] diff_dn;
   logic [ANGLE_W-1:0] sum_up;
   logic [ANGLE_W-1:0] next_cur;
   logic [ANGLE_W-1:0] set_angle;

   // Select the one entry looked at this cycle
   assign addr = cmd.advance  ? cmd.tick_index :
                 cmd.use_held ? held_ch_ff     : req_data.channel;

   assign cur  = current_ff[addr];
   assign tgt  = target_ff[addr];
   assign step = STEP_BASE - {1'b0, speed_ff[addr]};

   // Move one step toward the target, landing on it when close
   assign diff_up = tgt - cur;
   assign diff_dn = cur - tgt;
   assign sum_up  = cur + {1'b0, step};

   always_comb begin
      next_cur = cur;
      if (cur < tgt) begin
         if (diff_up < {1'b0, step}) begin
            next_cur = tgt;
         end else begin
            next_cur = sum_up;
         end
      end else if (cur > tgt) begin
         if (diff_dn < {1'b0, step}) begin
            next_cur = tgt;
         end else begin
            next_cur = cur - {1'b0, step};
         end
      end
   end

   // Clamp the requested target angle
   assign set_angle = (req_data.angle > ANGLE_MAX) ? ANGLE_MAX : req_data.angle;

   // Channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            current_ff[i] <= '0;
            target_ff[i]  <= '0;
            speed_ff[i]   <= '0;
         end
      end else begin
         if (cmd.set_target) begin
            target_ff[addr] <= set_angle;
            speed_ff[addr]  <= req_data.speed;
         end
         if (cmd.advance && mask_ff[addr]) begin
            current_ff[addr] <= next_cur;
         end
      end
   end

   // Present mask
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_valid) begin
         mask_ff <= csr_data;
      end
   end

   // Hold the channel of a read that waits for the response register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         held_ch_ff <= req_data.channel;
      end
   end

   // Response register
   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff.read_channel <= addr;
         rsp_data_ff.position     <= cur;
      end
   end

   assign status.rsp_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

FILE: rtl/mcss_ctrl.sv
// ----------------------------------------------------------------------------
// mcss_ctrl
// Sequencer: decodes accepted transactions, walks the channels on a tick and
// parks a read until the response register is free.
// ----------------------------------------------------------------------------
module mcss_ctrl
   import mcss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HOLD,
      ST_TICK
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [CHAN_W-1:0] count_ff;
   logic [CHAN_W-1:0] count_in;
   logic              accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   // Decode commands and next state
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      count_in   = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  KIND_SET: begin
                     cmd.set_target = 1'b1;
                  end
                  KIND_READ: begin
                     cmd.capture = 1'b1;
                     if (status.rsp_free) begin
                        cmd.load_rsp = 1'b1;
                     end else begin
                        state_in = ST_HOLD;
                     end
                  end
                  KIND_TICK: begin
                     count_in = '0;
                     state_in = ST_TICK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_HOLD: begin
            cmd.use_held = 1'b1;
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_TICK: begin
            cmd.advance    = 1'b1;
            cmd.tick_index = count_ff;
            count_in       = count_ff + CHAN_W'(1);
            if (count_ff == LAST_CHAN) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and channel counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // A tick blocks new transactions on the next cycle
   a_tick_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == KIND_TICK) |=> !req_ready)
      else $error("tick did not start a channel walk");

   // Never load the response register over an undelivered response
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("response overwritten");

   // Target writes, responses and channel steps are exclusive
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.set_target, cmd.load_rsp, cmd.advance}))
      else $error("conflicting datapath commands");

   // A walk ends on the last channel
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK && count_ff == LAST_CHAN) |=> (state_ff == ST_IDLE))
      else $error("channel walk did not end");

endmodule

FILE: rtl/multi_channel_servo_slew.sv
// ----------------------------------------------------------------------------
// multi_channel_servo_slew
// Sixteen-channel servo position slewer with set, read and tick transactions.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: set (writes a channel's target angle,
//   clamped to 180, and speed code), read (returns the channel's current
//   position on rsp_*), or tick (moves every present channel one step of
//   65 minus speed toward its target, landing exactly on it).
//   csr_* writes the 16-bit present mask; it is always ready.
//   A read's response is registered before it shows on rsp_*. A tick walks
//   the channels one per cycle, so req_ready stays low after a tick is
//   accepted until the walk has passed the last channel.
//   The response register decouples the sides: with a response waiting,
//   sets and ticks are still taken; a second read is taken and parked, and
//   req_ready stays low until rsp_ready frees the register.
//   Reset clears all positions, targets, speeds and the present mask;
//   the block is ready right after.
// ----------------------------------------------------------------------------
module multi_channel_servo_slew
   import mcss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [MASK_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mcss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .status    (status),
      .cmd       (cmd)
   );

   mcss_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
